@@ rtl/ads_pkg.sv @@
package ads_pkg;

  localparam int PC_W = 4;

  // Angle constants with 16 fraction bits (signed Q4.16), sized for the wrap arithmetic
  localparam logic signed [20:0] PI_Q16     = 21'sd205887;
  localparam logic signed [20:0] NEG_PI_Q16 = -21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
  localparam logic [16:0]        ONE_Q16    = 17'd65536;

  localparam logic signed [47:0] S32_MAX_W = 48'sd2147483647;
  localparam logic signed [47:0] S32_MIN_W = -48'sd2147483648;

  typedef enum logic [1:0] {
    REG_WINDOW_SAMPLES      = 2'd0,
    REG_FILTER_GAIN         = 2'd1,
    REG_INVERSE_WINDOW_TIME = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,
    OP_DIFF     = 4'd2,
    OP_ACCUM    = 4'd3,
    OP_MUL_SUM  = 4'd4,
    OP_OMEGA    = 4'd5,
    OP_MUL_KEEP = 4'd6,
    OP_TERM     = 4'd7,
    OP_MUL_GAIN = 4'd8,
    OP_FILT     = 4'd9,
    OP_EMIT     = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_IN    = 3'd2,
    COND_NOT_DUE  = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_t;

  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIFF      = 4'd1;
  localparam logic [PC_W-1:0] STEP_ACCUM     = 4'd2;
  localparam logic [PC_W-1:0] STEP_MUL_SUM   = 4'd3;
  localparam logic [PC_W-1:0] STEP_OMEGA     = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_KEEP  = 4'd5;
  localparam logic [PC_W-1:0] STEP_TERM      = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL_GAIN  = 4'd7;
  localparam logic [PC_W-1:0] STEP_FILT      = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd9;
  localparam logic [PC_W-1:0] STEP_BACK      = 4'd10;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic due;
  } flags_t;

  // Microprogram: a taken condition jumps to target, otherwise advance
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_IN,    target: STEP_IDLE};
      STEP_DIFF:     w = '{op: OP_DIFF,     cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ACCUM:    w = '{op: OP_ACCUM,    cond: COND_NOT_DUE,  target: STEP_EMIT};
      STEP_MUL_SUM:  w = '{op: OP_MUL_SUM,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_OMEGA:    w = '{op: OP_OMEGA,    cond: COND_NEVER,    target: STEP_IDLE};
      STEP_MUL_KEEP: w = '{op: OP_MUL_KEEP, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_TERM:     w = '{op: OP_TERM,     cond: COND_NEVER,    target: STEP_IDLE};
      STEP_MUL_GAIN: w = '{op: OP_MUL_GAIN, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_FILT:     w = '{op: OP_FILT,     cond: COND_NEVER,    target: STEP_IDLE};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_BACK:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_IDLE};
      default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

@@ rtl/angle_difference_speed_estimator.sv @@
// Angle-difference speed estimator.
// Input channel: angle_valid / angle_stall with rotor_angle (unsigned Q3.16 rad).
// A beat is taken when angle_valid is high and angle_stall is low.
// Output channel: speed_valid / speed_stall with speed_estimate and
// speed_updated; one output beat for every input beat, in order.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// window_samples (0), filter_gain (1) or inverse_window_time (2); other
// indexes are dropped. Write config only while the block is idle.
// A microcoded sequencer runs one short program per sample over a shared
// 32x32 multiplier. A sample that does not close a window steps through
// load, diff, accum, emit and back to idle; a sample that closes a window
// also runs mul_sum, omega, mul_keep, term, mul_gain and filt before emit,
// the three multiplies going through the one unit.
// angle_stall is high whenever the program is away from its idle step.
// When speed_stall holds the output register full, the program waits in
// its emit step and no new angle is taken.
// Reset (rst, synchronous) clears the sum, count, previous angle and
// filtered speed, and restores config to window 1, gain 1.0, inverse 1.0.
module angle_difference_speed_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               angle_valid,
  output logic               angle_stall,
  input  logic [18:0]        rotor_angle,
  output logic               speed_valid,
  input  logic               speed_stall,
  output logic signed [31:0] speed_estimate,
  output logic               speed_updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import ads_pkg::*;

  logic [7:0]         window_samples;
  logic [16:0]        filter_gain;
  logic [30:0]        inverse_window_time;

  uword_t             ctrl;
  flags_t             flags;
  logic               idle;
  logic               angle_fire;
  logic               out_busy;
  logic               emit;
  logic signed [31:0] dp_speed;
  logic               dp_updated;
  logic               dp_due;

  assign cfg_ready   = 1'b1;
  assign angle_stall = !idle;
  assign angle_fire  = angle_valid && idle;
  assign out_busy    = speed_valid && speed_stall;
  assign emit        = (ctrl.op == OP_EMIT) && !out_busy;

  assign flags = '{in_valid: angle_valid, out_busy: out_busy, due: dp_due};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples      <= 8'd1;
      filter_gain         <= ONE_Q16;
      inverse_window_time <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SAMPLES:      window_samples      <= cfg_data[7:0];
        REG_FILTER_GAIN:         filter_gain         <= cfg_data[16:0];
        REG_INVERSE_WINDOW_TIME: inverse_window_time <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ads_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  ads_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .angle_fire          (angle_fire),
    .rotor_angle         (rotor_angle),
    .window_samples      (window_samples),
    .filter_gain         (filter_gain),
    .inverse_window_time (inverse_window_time),
    .speed               (dp_speed),
    .updated             (dp_updated),
    .due                 (dp_due)
  );

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_valid <= 1'b0;
    end else if (emit) begin
      speed_valid <= 1'b1;
    end else if (!speed_stall) begin
      speed_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      speed_estimate <= dp_speed;
      speed_updated  <= dp_updated;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && !angle_stall) |=> angle_stall)
    else $error("sequencer took a second angle beat without running its program");

  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(speed_valid) |-> $past(angle_stall))
    else $error("output beat appeared while the sequencer was idle");

endmodule

@@ rtl/ads_sequencer.sv @@
module ads_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  ads_pkg::flags_t flags,
  output ads_pkg::uword_t ctrl,
  output logic            idle
);
  import ads_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            taken;

  assign ctrl = ucode(pc);
  assign idle = (pc == STEP_IDLE);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_IN:    taken = !flags.in_valid;
      COND_NOT_DUE:  taken = !flags.due;
      COND_OUT_BUSY: taken = flags.out_busy;
      default:       taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/ads_datapath.sv @@
module ads_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ads_pkg::uword_t    ctrl,
  input  logic               angle_fire,
  input  logic [18:0]        rotor_angle,
  input  logic [7:0]         window_samples,
  input  logic [16:0]        filter_gain,
  input  logic [30:0]        inverse_window_time,
  output logic signed [31:0] speed,
  output logic               updated,
  output logic               due
);
  import ads_pkg::*;

  logic signed [18:0] angle_w;
  logic signed [18:0] prev;
  logic signed [18:0] diff;
  logic signed [31:0] sum;
  logic signed [31:0] fs;
  logic signed [31:0] omega;
  logic signed [31:0] term;
  logic [7:0]         count;
  logic signed [63:0] prod;
  logic               upd;

  logic signed [20:0] raw_in;
  logic signed [20:0] d_raw;
  logic signed [20:0] d_wrap;
  logic signed [18:0] angle_wrapped;
  logic [16:0]        k;
  logic [16:0]        one_minus_k;
  logic signed [31:0] mul_a;
  logic [30:0]        mul_b;
  logic signed [63:0] prod_next;
  logic signed [32:0] acc_sum;
  logic signed [32:0] filt_sum;

  always_comb begin
    raw_in        = $signed({2'b00, rotor_angle});
    angle_wrapped = (raw_in > PI_Q16) ? 19'(raw_in - TWO_PI_Q16) : raw_in[18:0];

    d_raw = $signed({{2{angle_w[18]}}, angle_w}) - $signed({{2{prev[18]}}, prev});
    if (d_raw > PI_Q16) begin
      d_wrap = d_raw - TWO_PI_Q16;
    end else if (d_raw < NEG_PI_Q16) begin
      d_wrap = d_raw + TWO_PI_Q16;
    end else begin
      d_wrap = d_raw;
    end

    k           = (filter_gain > ONE_Q16) ? ONE_Q16 : filter_gain;
    one_minus_k = ONE_Q16 - k;

    case (ctrl.op)
      OP_MUL_KEEP: begin
        mul_a = fs;
        mul_b = {14'd0, one_minus_k};
      end
      OP_MUL_GAIN: begin
        mul_a = omega;
        mul_b = {14'd0, k};
      end
      default: begin
        mul_a = sum;
        mul_b = inverse_window_time;
      end
    endcase
    prod_next = mul_a * $signed({1'b0, mul_b});

    acc_sum  = $signed({sum[31], sum}) + $signed({{14{diff[18]}}, diff});
    filt_sum = $signed({term[31], term}) + $signed({prod[47], prod[47:16]});
  end

  assign due     = (count >= window_samples);
  assign speed   = fs;
  assign updated = upd;

  // model state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      sum   <= '0;
      count <= '0;
      fs    <= '0;
      upd   <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_LOAD: begin
          if (angle_fire) begin
            upd <= 1'b0;
          end
        end
        OP_DIFF: begin
          prev  <= angle_w;
          count <= count + 8'd1;
        end
        OP_ACCUM: begin
          sum <= sat32($signed({{15{acc_sum[32]}}, acc_sum}));
        end
        OP_FILT: begin
          fs    <= sat32($signed({{15{filt_sum[32]}}, filt_sum}));
          sum   <= '0;
          count <= '0;
          upd   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (angle_fire) begin
          angle_w <= angle_wrapped;
        end
      end
      OP_DIFF:     diff  <= d_wrap[18:0];
      OP_MUL_SUM,
      OP_MUL_KEEP,
      OP_MUL_GAIN: prod  <= prod_next;
      OP_OMEGA:    omega <= sat32($signed(prod[63:16]));
      OP_TERM:     term  <= $signed(prod[47:16]);
      default: begin
      end
    endcase
  end

endmodule
